[design/lss_pkg.sv]
// Shared types and constants for the LIFO stack with search and remove.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package lss_pkg;

  // Port field widths
  localparam int OPCODE_W = 2;
  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 4;

  // Default sizing
  localparam int DEPTH_DEF     = 8;
  localparam int KEY_WIDTH_DEF = 32;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming word
    logic compare;  // register the per-entry match vector
    logic apply;    // update the stack and load the result register
  } lss_cmd_t;

endpackage

`default_nettype wire

[design/lss_ctrl.sv]
// Sequencing controller for the LIFO stack: capture, compare, apply.
// Depends on lss_pkg for the command struct.
`default_nettype none

module lss_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lss_pkg::lss_cmd_t      cmd
);
  import lss_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_APPLY = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_MATCH;
      end
      S_MATCH: begin
        cmd.compare = 1'b1;
        state_nxt   = S_APPLY;
      end
      S_APPLY: begin
        // hold until the result register can take the new word
        if (slot_free) begin
          cmd.apply = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.apply) out_valid_nxt = 1'b1;
    else           out_valid_nxt = out_valid_r && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[design/lss_dp.sv]
// Datapath for the LIFO stack: entry registers, fill level, match vector
// and result register. Depends on lss_pkg for opcodes, status and commands.
`default_nettype none

module lss_dp #(
  parameter int DEPTH     = lss_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = lss_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire lss_pkg::lss_cmd_t                 cmd,
  input  wire logic [lss_pkg::OPCODE_W-1:0]      in_opcode,
  input  wire logic [lss_pkg::KEY_W-1:0]         in_key,
  output logic [lss_pkg::STATUS_W-1:0]           out_status,
  output logic                                   out_found,
  output logic [lss_pkg::VALUE_W-1:0]            out_popped_value,
  output logic [lss_pkg::VALUE_W-1:0]            out_top_value,
  output logic [lss_pkg::COUNT_W-1:0]            out_entry_count,
  output logic                                   out_is_full,
  output logic                                   out_is_empty
);
  import lss_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [KEY_WIDTH-1:0] entries_r [DEPTH];
  logic [KEY_WIDTH-1:0] entries_nxt [DEPTH];
  logic [KEY_WIDTH-1:0] shifted [DEPTH];
  logic [CNT_W-1:0]     fill_r, fill_nxt;
  op_t                  op_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [DEPTH-1:0]     match_r, match_nxt;
  logic [DEPTH-1:0]     shift_mask;
  logic                 hit;

  logic [KEY_W+KEY_WIDTH-1:0]   key_ext;
  logic [CNT_W-1:0]             top_pos, cur_pos;
  logic [KEY_WIDTH-1:0]         popped, top;
  logic [KEY_WIDTH+VALUE_W-1:0] popped_ext, top_ext;
  logic [CNT_W+COUNT_W-1:0]     cnt_ext;
  status_t                      status;
  logic                         found;

  assign key_ext = {{KEY_WIDTH{1'b0}}, in_key};

  // Per-entry compare, valid slots only
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_nxt[i] = (CNT_W'(i) < fill_r) && (entries_r[i] == key_r);
    end
  end

  assign hit = |match_r;

  // Entries at and above the topmost match move down one slot
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      shift_mask[i] = hit && ((match_r >> (i + 1)) == '0);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_shift
    if (g < DEPTH - 1) begin : g_mid
      assign shifted[g] = entries_r[g + 1];
    end else begin : g_last
      assign shifted[g] = entries_r[g];
    end
  end

  assign cur_pos = fill_r - CNT_W'(1);

  always_comb begin
    entries_nxt = entries_r;
    fill_nxt    = fill_r;
    status      = ST_OK;
    found       = 1'b0;
    popped      = '0;
    case (op_r)
      OP_PUSH: begin
        if (fill_r >= CNT_W'(DEPTH)) begin
          status = ST_FULL;
        end else begin
          entries_nxt[fill_r[IDX_W-1:0]] = key_r;
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (fill_r == '0) begin
          status = ST_EMPTY;
        end else begin
          fill_nxt = cur_pos;
          popped   = entries_r[cur_pos[IDX_W-1:0]];
        end
      end
      OP_SEARCH: begin
        found  = hit;
        status = hit ? ST_OK : ST_NOT_FOUND;
      end
      OP_REMOVE: begin
        if (fill_r == '0) begin
          status = ST_EMPTY;
        end else if (hit) begin
          found = 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            if (shift_mask[i]) entries_nxt[i] = shifted[i];
          end
          fill_nxt = cur_pos;
        end else begin
          status = ST_NOT_FOUND;
        end
      end
      default: status = ST_OK;
    endcase
  end

  assign top_pos    = fill_nxt - CNT_W'(1);
  assign top        = (fill_nxt == '0) ? '0 : entries_nxt[top_pos[IDX_W-1:0]];
  assign top_ext    = {{VALUE_W{1'b0}}, top};
  assign popped_ext = {{VALUE_W{1'b0}}, popped};
  assign cnt_ext    = {{COUNT_W{1'b0}}, fill_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.apply) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_t'(in_opcode);
      key_r <= key_ext[KEY_WIDTH-1:0];
    end
    if (cmd.compare) match_r <= match_nxt;
    if (cmd.apply) begin
      entries_r        <= entries_nxt;
      out_status       <= status;
      out_found        <= found;
      out_popped_value <= popped_ext[VALUE_W-1:0];
      out_top_value    <= top_ext[VALUE_W-1:0];
      out_entry_count  <= cnt_ext[COUNT_W-1:0];
      out_is_full      <= (fill_nxt == CNT_W'(DEPTH));
      out_is_empty     <= (fill_nxt == '0);
    end
  end

endmodule

`default_nettype wire

[design/lifo_stack_with_search_and_remove_top.sv]
// Sequencing: each accepted word passes through capture, compare and apply, in that
//   order, and the apply step loads the result register. A held result stalls only
//   the apply step.
// Flow: a new word is accepted only once the previous word has been applied.
// Reset: synchronous active-low rst_n empties the stack and drops out_valid.
// Depends on lss_pkg, lss_ctrl and lss_dp.
`default_nettype none

module lifo_stack_with_search_and_remove_top #(
  parameter int DEPTH     = lss_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH = lss_pkg::KEY_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input words: opcode and key
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lss_pkg::OPCODE_W-1:0]    in_opcode,
  input  wire logic [lss_pkg::KEY_W-1:0]       in_key,
  // result words: one per input word
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lss_pkg::STATUS_W-1:0]         out_status,
  output logic                                 out_found,
  output logic [lss_pkg::VALUE_W-1:0]          out_popped_value,
  output logic [lss_pkg::VALUE_W-1:0]          out_top_value,
  output logic [lss_pkg::COUNT_W-1:0]          out_entry_count,
  output logic                                 out_is_full,
  output logic                                 out_is_empty
);
  import lss_pkg::*;

  lss_cmd_t cmd;

  // Controller: walks each word through capture, compare and apply, and
  // owns the result valid flag so a new word can start while one waits.
  lss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Datapath: entry registers with parallel compare, gap-closing shift on
  // remove, and the result register that holds the outgoing word.
  lss_dp #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_opcode        (in_opcode),
    .in_key           (in_key),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_popped_value (out_popped_value),
    .out_top_value    (out_top_value),
    .out_entry_count  (out_entry_count),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty)
  );

endmodule

`default_nettype wire

[tb/tb_lss_shadow_pkg.sv]
// Shadow copy of the LIFO stack: predicts each result word and checks the DUT's output.
// Depends on lss_pkg for the opcode and status codes and for the port widths.
package tb_lss_shadow_pkg;
  import lss_pkg::*;

  typedef struct packed {
    status_t            status;
    logic               found;
    logic [VALUE_W-1:0] popped;
    logic [VALUE_W-1:0] top;
    logic [COUNT_W-1:0] count;
    logic               full;
    logic               empty;
  } stack_result_t;

  class stack_shadow;
    logic [KEY_W-1:0] entries [DEPTH_DEF];
    int unsigned      fill;
    stack_result_t    pending_results [$];
    int unsigned      errors;
    int unsigned      words_seen;
    int unsigned      results_seen;
    int unsigned      op_seen [4];
    int unsigned      status_seen [4];

    // Apply one accepted word to the shadow stack and queue the result it implies.
    function void note_word(op_t op, logic [KEY_W-1:0] key);
      stack_result_t r;
      int            hit_pos;
      r = '0;
      r.status = ST_OK;
      hit_pos = -1;
      for (int i = 0; i < int'(fill); i++) begin
        if (entries[i] == key) hit_pos = i;
      end
      case (op)
        OP_PUSH: begin
          if (fill >= DEPTH_DEF) begin
            r.status = ST_FULL;
          end else begin
            entries[fill] = key;
            fill++;
          end
        end
        OP_POP: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            fill--;
            r.popped = entries[fill];
          end
        end
        OP_SEARCH: begin
          r.found = (hit_pos >= 0);
          if (hit_pos < 0) r.status = ST_NOT_FOUND;
        end
        default: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else if (hit_pos < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            // close the gap, keeping the order of the words above
            r.found = 1'b1;
            for (int i = hit_pos; i + 1 < int'(fill); i++) entries[i] = entries[i + 1];
            fill--;
          end
        end
      endcase
      r.top   = (fill != 0) ? entries[fill - 1] : '0;
      r.count = fill[COUNT_W-1:0];
      r.full  = (fill >= DEPTH_DEF);
      r.empty = (fill == 0);
      pending_results.push_back(r);
      words_seen++;
      op_seen[op]++;
      status_seen[r.status]++;
    endfunction

    function void field_check(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got,
                              realtime stamp);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h actual %0h", stamp, name, want, got);
      end
    endfunction

    // Compare one result word with the oldest prediction.
    function void check_result(stack_result_t got, realtime stamp);
      stack_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: result word with nothing expected, actual %0h", stamp, got);
        return;
      end
      want = pending_results.pop_front();
      results_seen++;
      field_check("status", VALUE_W'(want.status), VALUE_W'(got.status), stamp);
      field_check("found", VALUE_W'(want.found), VALUE_W'(got.found), stamp);
      field_check("popped_value", want.popped, got.popped, stamp);
      field_check("top_value", want.top, got.top, stamp);
      field_check("entry_count", VALUE_W'(want.count), VALUE_W'(got.count), stamp);
      field_check("is_full", VALUE_W'(want.full), VALUE_W'(got.full), stamp);
      field_check("is_empty", VALUE_W'(want.empty), VALUE_W'(got.empty), stamp);
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass
endpackage

[tb/tb_lifo_stack_with_search_and_remove_top.sv]
// Testbench for the LIFO stack with search and remove: directed corner words, then
// random words with idles on both sides. Depends on lss_pkg and tb_lss_shadow_pkg.
module tb_lifo_stack_with_search_and_remove_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lss_pkg::*;
  import tb_lss_shadow_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int RANDOM_WORDS = 1000;
  localparam int IDLE_PCT     = 18;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OPCODE_W-1:0] in_opcode = '0;
  logic [KEY_W-1:0]    in_key = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic                out_found;
  logic [VALUE_W-1:0]  out_popped_value;
  logic [VALUE_W-1:0]  out_top_value;
  logic [COUNT_W-1:0]  out_entry_count;
  logic                out_is_full;
  logic                out_is_empty;

  // Set during the stretch where neither side idles.
  bit                  no_idle = 1'b0;
  logic [KEY_W-1:0]    key_pool [8];
  stack_shadow         shadow = new();

  lifo_stack_with_search_and_remove_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_key           (in_key),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_popped_value (out_popped_value),
    .out_top_value    (out_top_value),
    .out_entry_count  (out_entry_count),
    .out_is_full      (out_is_full),
    .out_is_empty     (out_is_empty)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stall the result side at random; drive ready only at the falling edge.
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Sample result words at the rising edge and check them against the shadow stack.
  always @(posedge clk) begin
    stack_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status = status_t'(out_status);
      got.found  = out_found;
      got.popped = out_popped_value;
      got.top    = out_top_value;
      got.count  = out_entry_count;
      got.full   = out_is_full;
      got.empty  = out_is_empty;
      shadow.check_result(got, $realtime);
    end
  end

  // Offer one word: idle for a random number of cycles first, then hold valid and
  // payload until the handshake, and note the word once it is accepted.
  task automatic send_word(input op_t op, input logic [KEY_W-1:0] key);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_key    <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.note_word(op, key);
  endtask

  // Pick a key: often one already held (so search and remove hit), often one from a
  // small pool (so pushes make duplicates), sometimes a fully random one.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(99);
    if (shadow.fill > 0 && r < 35) return shadow.entries[$urandom_range(shadow.fill - 1)];
    if (r < 80) return key_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  // Pick an operation; alternate filling and draining trends so the stack sweeps
  // from empty to full and back many times.
  function automatic op_t pick_op(input bit draining);
    int unsigned r;
    r = $urandom_range(99);
    if (!draining) begin
      if (r < 50) return OP_PUSH;
      if (r < 62) return OP_POP;
      if (r < 80) return OP_SEARCH;
      return OP_REMOVE;
    end
    if (r < 20) return OP_PUSH;
    if (r < 50) return OP_POP;
    if (r < 65) return OP_SEARCH;
    return OP_REMOVE;
  endfunction

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom;

    // Hold reset low, then release it at a falling edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty stack: pop, remove and search all have nothing to act on.
    send_word(OP_POP, 32'hA5A5_A5A5);
    send_word(OP_REMOVE, 32'h0000_0000);
    send_word(OP_SEARCH, 32'h0000_0000);
    // Extreme keys and a duplicate.
    send_word(OP_PUSH, 32'h0000_0000);
    send_word(OP_PUSH, 32'hFFFF_FFFF);
    send_word(OP_PUSH, 32'h5A5A_5A5A);
    send_word(OP_PUSH, 32'hFFFF_FFFF);
    send_word(OP_SEARCH, 32'hFFFF_FFFF);
    send_word(OP_SEARCH, 32'h1234_5678);
    // Remove with no match leaves the stack alone.
    send_word(OP_REMOVE, 32'h1234_5678);
    // Remove the topmost of two equal keys, then the bottom word (gap closes).
    send_word(OP_REMOVE, 32'hFFFF_FFFF);
    send_word(OP_REMOVE, 32'h0000_0000);
    // Fill to the brim, then try one more push.
    for (int k = 1; k <= 6; k++) send_word(OP_PUSH, KEY_W'(k));
    send_word(OP_PUSH, 32'h0000_0007);
    // Remove from the middle of a full stack, then pop with a key that must be ignored.
    send_word(OP_REMOVE, 32'h0000_0003);
    send_word(OP_POP, 32'hFFFF_FFFF);

    // Random words; one long stretch runs with no idling on either side.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      op_t op;
      no_idle = (n >= 400 && n < 550);
      op = pick_op((n / 40) % 2 == 1);
      send_word(op, (op == OP_POP) ? KEY_W'($urandom) : pick_key());
    end
    no_idle = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: wait for every predicted word, then keep the clock running to catch strays.
    while (shadow.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Covered %0d words (push %0d, pop %0d, search %0d, remove %0d), %0d results checked",
             shadow.words_seen, shadow.op_seen[OP_PUSH], shadow.op_seen[OP_POP],
             shadow.op_seen[OP_SEARCH], shadow.op_seen[OP_REMOVE], shadow.results_seen);
    $display("Outcomes: %0d ok, %0d full rejects, %0d empty, %0d not found; %0d mismatches",
             shadow.status_seen[ST_OK], shadow.status_seen[ST_FULL],
             shadow.status_seen[ST_EMPTY], shadow.status_seen[ST_NOT_FOUND], shadow.errors);
    if (shadow.errors == 0) begin
      $display("PASS lifo_stack_with_search_and_remove_top");
    end else begin
      $display("FAIL lifo_stack_with_search_and_remove_top");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 1000 words).
  initial begin
    #2_000_000;
    $display("Timeout with %0d result words still expected", shadow.pending());
    $display("FAIL lifo_stack_with_search_and_remove_top");
    $finish;
  end
endmodule
